// File: src/sawfr_pkg.sv
package sawfr_pkg;

  localparam int unsigned MAX_FRAME_DEF = 128;

  localparam logic [7:0] RESP_CSUM_ERR = 8'h39;
  localparam logic [7:0] RESP_SEQ_ERR  = 8'h38;
  localparam logic [7:0] SUM_GOOD      = 8'hFF;

  typedef enum logic [2:0] {
    KIND_DATA     = 3'd0,
    KIND_ACCEPT   = 3'd1,
    KIND_CSUM_ERR = 3'd2,
    KIND_SEQ_ERR  = 3'd3,
    KIND_LEN_ERR  = 3'd4
  } kind_t;

  typedef enum logic [3:0] {
    PH_CSUM = 4'b0001,
    PH_SEQ  = 4'b0010,
    PH_LEN  = 4'b0100,
    PH_DATA = 4'b1000
  } phase_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data_byte;
    logic [6:0] byte_index;
    logic [7:0] resp_first;
    logic [7:0] resp_second;
    logic [6:0] payload_len;
    logic       last;
  } result_t;

endpackage

// File: src/stop_and_wait_frame_receiver.sv
// Stop-and-wait frame receiver. Frame bytes (checksum, sequence, length, then
// payload) enter one per cycle unless stalled. Each payload byte is queued as a
// tentative result; the frame's verdict (accept with ACK bytes, checksum,
// sequence or length error) follows as the item with last set. Each byte is
// handled in one pass between the input and a three-entry result queue, so a
// byte is taken in every cycle while at most one result waits. The last payload
// byte yields two results, so with the output draining every cycle a frame with
// payload stalls the input at its end; an empty or dropped frame does not.
module stop_and_wait_frame_receiver #(
  parameter int unsigned MAX_FRAME = sawfr_pkg::MAX_FRAME_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] out_kind,
  output logic [7:0] out_data_byte,
  output logic [6:0] out_byte_index,
  output logic [7:0] out_resp_first,
  output logic [7:0] out_resp_second,
  output logic [6:0] out_payload_len,
  output logic       out_last
);

  localparam int unsigned LEN_W = $clog2(MAX_FRAME - 2);
  localparam int unsigned EXT_W = (LEN_W > 7) ? LEN_W : 7;
  localparam logic [8:0]  LEN_BOUND = 9'(MAX_FRAME - 3);
  localparam logic [1:0]  Q_DEPTH = 2'd3;

  sawfr_pkg::phase_t  phase_r, phase_nxt;
  logic [7:0]         csum_r, csum_nxt;
  logic [7:0]         seq_r, seq_nxt;
  logic [LEN_W-1:0]   msg_len_r, msg_len_nxt;
  logic [LEN_W-1:0]   bcount_r, bcount_nxt;
  logic [7:0]         sum_r, sum_nxt;
  logic               exp_r, exp_nxt;

  sawfr_pkg::result_t q_mem [Q_DEPTH];
  logic [1:0]         wr_r, wr_nxt, rd_r, rd_nxt, cnt_r, cnt_nxt;

  logic               accept, pop, too_long, done, csum_ok, seq_ok, new_bit;
  logic [8:0]         sum_wide;
  logic [7:0]         sum_add, vsum;
  logic [LEN_W:0]     cnt_inc;
  logic [EXT_W-1:0]   idx_ext, plen_ext;
  logic [1:0]         n_push, wr_plus1;
  sawfr_pkg::result_t res0, res1, vres;

  function automatic logic [1:0] wrap_inc(input logic [1:0] p);
    wrap_inc = (p == Q_DEPTH - 2'd1) ? 2'd0 : p + 2'd1;
  endfunction

  assign in_stall  = (cnt_r > 2'd1);
  assign accept    = in_valid && !in_stall;
  assign out_valid = (cnt_r != 2'd0);
  assign pop       = out_valid && !out_stall;

  // End-around-carry add of the incoming byte
  assign sum_wide = {1'b0, sum_r} + {1'b0, in_rx_byte};
  assign sum_add  = sum_wide[7:0] + {7'd0, sum_wide[8]};
  assign too_long = ({1'b0, in_rx_byte} > LEN_BOUND);
  assign cnt_inc  = {1'b0, bcount_r} + (LEN_W + 1)'(1);
  assign done     = (cnt_inc >= {1'b0, msg_len_r});

  assign vsum     = (phase_r == sawfr_pkg::PH_DATA) ? sum_add : sum_r;
  assign csum_ok  = ((vsum + csum_r) == sawfr_pkg::SUM_GOOD);
  assign seq_ok   = (seq_r == {7'd0, exp_r});
  assign new_bit  = ~exp_r;
  assign idx_ext  = EXT_W'(bcount_r);
  assign plen_ext = EXT_W'(msg_len_r);

  always_comb begin
    vres = '0;
    vres.last = 1'b1;
    if (!csum_ok) begin
      vres.kind        = sawfr_pkg::KIND_CSUM_ERR;
      vres.resp_first  = sawfr_pkg::RESP_CSUM_ERR;
      vres.resp_second = sawfr_pkg::RESP_CSUM_ERR;
    end else if (!seq_ok) begin
      vres.kind        = sawfr_pkg::KIND_SEQ_ERR;
      vres.resp_first  = sawfr_pkg::RESP_SEQ_ERR;
      vres.resp_second = sawfr_pkg::RESP_SEQ_ERR;
    end else begin
      vres.kind        = sawfr_pkg::KIND_ACCEPT;
      vres.resp_first  = ~{7'd0, new_bit};
      vres.resp_second = {7'd0, new_bit};
      vres.payload_len = (phase_r == sawfr_pkg::PH_DATA) ? plen_ext[6:0] : 7'd0;
    end
  end

  always_comb begin
    phase_nxt   = phase_r;
    csum_nxt    = csum_r;
    seq_nxt     = seq_r;
    msg_len_nxt = msg_len_r;
    bcount_nxt  = bcount_r;
    sum_nxt     = sum_r;
    exp_nxt     = exp_r;
    res0        = '0;
    res1        = vres;
    n_push      = 2'd0;
    case (phase_r)
      sawfr_pkg::PH_CSUM: begin
        csum_nxt   = in_rx_byte;
        sum_nxt    = 8'd0;
        bcount_nxt = '0;
        phase_nxt  = sawfr_pkg::PH_SEQ;
      end
      sawfr_pkg::PH_SEQ: begin
        seq_nxt   = in_rx_byte;
        phase_nxt = sawfr_pkg::PH_LEN;
      end
      sawfr_pkg::PH_LEN: begin
        if (too_long) begin
          // drop the frame and ask for a resend
          res0.kind        = sawfr_pkg::KIND_LEN_ERR;
          res0.resp_first  = sawfr_pkg::RESP_CSUM_ERR;
          res0.resp_second = sawfr_pkg::RESP_CSUM_ERR;
          res0.last        = 1'b1;
          n_push           = 2'd1;
          phase_nxt        = sawfr_pkg::PH_CSUM;
          sum_nxt          = 8'd0;
          bcount_nxt       = '0;
        end else begin
          msg_len_nxt = in_rx_byte[LEN_W-1:0];
          bcount_nxt  = '0;
          if (in_rx_byte == 8'd0) begin
            res0      = vres;
            n_push    = 2'd1;
            exp_nxt   = (csum_ok && seq_ok) ? new_bit : exp_r;
            phase_nxt = sawfr_pkg::PH_CSUM;
            sum_nxt   = 8'd0;
          end else begin
            phase_nxt = sawfr_pkg::PH_DATA;
          end
        end
      end
      sawfr_pkg::PH_DATA: begin
        res0.kind       = sawfr_pkg::KIND_DATA;
        res0.data_byte  = in_rx_byte;
        res0.byte_index = idx_ext[6:0];
        n_push          = 2'd1;
        sum_nxt         = sum_add;
        bcount_nxt      = cnt_inc[LEN_W-1:0];
        if (done) begin
          n_push     = 2'd2;
          exp_nxt    = (csum_ok && seq_ok) ? new_bit : exp_r;
          phase_nxt  = sawfr_pkg::PH_CSUM;
          sum_nxt    = 8'd0;
          bcount_nxt = '0;
        end
      end
      default: begin
        phase_nxt = sawfr_pkg::PH_CSUM;
      end
    endcase
  end

  assign wr_plus1 = wrap_inc(wr_r);

  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (accept) begin
      case (n_push)
        2'd1:    wr_nxt = wr_plus1;
        2'd2:    wr_nxt = wrap_inc(wr_plus1);
        default: wr_nxt = wr_r;
      endcase
      cnt_nxt = cnt_r + n_push;
    end
    if (pop) begin
      rd_nxt  = wrap_inc(rd_r);
      cnt_nxt = cnt_nxt - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= sawfr_pkg::PH_CSUM;
      csum_r    <= 8'd0;
      seq_r     <= 8'd0;
      msg_len_r <= '0;
      bcount_r  <= '0;
      sum_r     <= 8'd0;
      exp_r     <= 1'b0;
      wr_r      <= 2'd0;
      rd_r      <= 2'd0;
      cnt_r     <= 2'd0;
    end else begin
      if (accept) begin
        phase_r   <= phase_nxt;
        csum_r    <= csum_nxt;
        seq_r     <= seq_nxt;
        msg_len_r <= msg_len_nxt;
        bcount_r  <= bcount_nxt;
        sum_r     <= sum_nxt;
        exp_r     <= exp_nxt;
      end
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && (n_push != 2'd0)) begin
      q_mem[wr_r] <= res0;
    end
    if (accept && (n_push == 2'd2)) begin
      q_mem[wr_plus1] <= res1;
    end
  end

  assign out_kind        = q_mem[rd_r].kind;
  assign out_data_byte   = q_mem[rd_r].data_byte;
  assign out_byte_index  = q_mem[rd_r].byte_index;
  assign out_resp_first  = q_mem[rd_r].resp_first;
  assign out_resp_second = q_mem[rd_r].resp_second;
  assign out_payload_len = q_mem[rd_r].payload_len;
  assign out_last        = q_mem[rd_r].last;

  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= Q_DEPTH)
    else $error("result queue overflow");

  a_count_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == sawfr_pkg::PH_DATA |-> bcount_r < msg_len_r)
    else $error("payload count reached frame length inside payload phase");

  a_csum_to_seq: assert property (@(posedge clk) disable iff (!rst_n)
    accept && phase_r == sawfr_pkg::PH_CSUM |=> phase_r == sawfr_pkg::PH_SEQ)
    else $error("checksum byte did not advance to sequence phase");

  a_last_byte_two: assert property (@(posedge clk) disable iff (!rst_n)
    accept && phase_r == sawfr_pkg::PH_DATA && done |=>
      {1'b0, cnt_r} == {1'b0, $past(cnt_r)} + 3'd2 - {2'd0, $past(pop)})
    else $error("last payload byte did not queue two results");

endmodule

// File: bench/sawfr_frame_checker.sv
module sawfr_frame_checker
  import sawfr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [7:0] in_rx_byte,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic [2:0] out_kind,
  input  logic [7:0] out_data_byte,
  input  logic [6:0] out_byte_index,
  input  logic [7:0] out_resp_first,
  input  logic [7:0] out_resp_second,
  input  logic [6:0] out_payload_len,
  input  logic       out_last,
  output int         mismatches,
  output int         results_due
);

  localparam int unsigned MAX_LEN = MAX_FRAME_DEF - 3;

  phase_t     phase;
  logic [7:0] rx_csum;
  logic [7:0] rx_seq;
  logic [6:0] frame_len;
  logic [6:0] payload_pos;
  logic [7:0] payload_sum;
  logic       seq_bit;
  result_t    due_q[$];
  int         errs;

  function automatic result_t make_result(kind_t k, logic [7:0] data, logic [6:0] idx,
                                          logic [7:0] r1, logic [7:0] r2,
                                          logic [6:0] plen, logic fin);
    result_t r;
    r.kind        = k;
    r.data_byte   = data;
    r.byte_index  = idx;
    r.resp_first  = r1;
    r.resp_second = r2;
    r.payload_len = plen;
    r.last        = fin;
    return r;
  endfunction

  task automatic restart_frame();
    phase       = PH_CSUM;
    payload_pos = '0;
    payload_sum = '0;
  endtask

  task automatic settle_frame();
    logic [7:0] total;
    total = payload_sum + rx_csum;
    if (total != SUM_GOOD) begin
      due_q.push_back(make_result(KIND_CSUM_ERR, '0, '0, RESP_CSUM_ERR, RESP_CSUM_ERR, '0, 1'b1));
    end else if (rx_seq != {7'b0, seq_bit}) begin
      due_q.push_back(make_result(KIND_SEQ_ERR, '0, '0, RESP_SEQ_ERR, RESP_SEQ_ERR, '0, 1'b1));
    end else begin
      // ACK carries the complement of the new bit, then the bit itself
      seq_bit = ~seq_bit;
      due_q.push_back(make_result(KIND_ACCEPT, '0, '0, ~{7'b0, seq_bit}, {7'b0, seq_bit},
                                  frame_len, 1'b1));
    end
    restart_frame();
  endtask

  task automatic take_rx_byte(input logic [7:0] b);
    logic [8:0] s;
    case (phase)
      PH_CSUM: begin
        rx_csum     = b;
        payload_sum = '0;
        payload_pos = '0;
        phase       = PH_SEQ;
      end
      PH_SEQ: begin
        rx_seq = b;
        phase  = PH_LEN;
      end
      PH_LEN: begin
        if (b > MAX_LEN) begin
          due_q.push_back(make_result(KIND_LEN_ERR, '0, '0, RESP_CSUM_ERR, RESP_CSUM_ERR,
                                      '0, 1'b1));
          restart_frame();
        end else begin
          frame_len   = b[6:0];
          payload_pos = '0;
          if (b == 8'd0) settle_frame();
          else phase = PH_DATA;
        end
      end
      default: begin
        due_q.push_back(make_result(KIND_DATA, b, payload_pos, '0, '0, '0, 1'b0));
        // end-around carry: fold the ninth bit back in
        s = {1'b0, payload_sum} + b;
        if (s[8]) s = s + 9'd1;
        payload_sum = s[7:0];
        payload_pos = payload_pos + 7'd1;
        if (payload_pos >= frame_len) settle_frame();
      end
    endcase
  endtask

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      errs++;
      $display("%0t: %s expected %0h got %0h", $time, name, want, got);
    end
  endtask

  task automatic check_result();
    result_t want;
    if (due_q.size() == 0) begin
      errs++;
      $display("%0t: result expected none got kind %0h data %0h last %0h",
               $time, out_kind, out_data_byte, out_last);
    end else begin
      want = due_q.pop_front();
      check_field("kind", want.kind, out_kind);
      check_field("data_byte", want.data_byte, out_data_byte);
      check_field("byte_index", want.byte_index, out_byte_index);
      check_field("resp_first", want.resp_first, out_resp_first);
      check_field("resp_second", want.resp_second, out_resp_second);
      check_field("payload_len", want.payload_len, out_payload_len);
      check_field("last", want.last, out_last);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      restart_frame();
      rx_csum   = '0;
      rx_seq    = '0;
      frame_len = '0;
      seq_bit   = 1'b0;
      errs      = 0;
      due_q.delete();
    end else begin
      // compare first: a result never stems from the request taken on the same edge
      if (out_valid && !out_stall) check_result();
      if (in_valid && !in_stall) take_rx_byte(in_rx_byte);
    end
    mismatches  <= errs;
    results_due <= due_q.size();
  end

endmodule

// File: bench/stop_and_wait_frame_receiver_tb.sv
module stop_and_wait_frame_receiver_tb;
  import sawfr_pkg::*;

  localparam int unsigned MAX_LEN = MAX_FRAME_DEF - 3;
  localparam int QUIET_LIMIT  = 5000;
  localparam int DRAIN_CYCLES = 20;
  localparam int HOLD_CYCLES  = 300;
  localparam int BYTE_TARGET  = 1350;

  logic       clk        = 1'b0;
  logic       rst_n      = 1'b0;
  logic       in_valid   = 1'b0;
  logic       in_stall;
  logic [7:0] in_rx_byte = 8'd0;
  logic       out_valid;
  logic       out_stall  = 1'b0;
  logic [2:0] out_kind;
  logic [7:0] out_data_byte;
  logic [6:0] out_byte_index;
  logic [7:0] out_resp_first;
  logic [7:0] out_resp_second;
  logic [6:0] out_payload_len;
  logic       out_last;

  int         mismatches;
  int         results_due;
  int         bytes_sent = 0;
  int         frame_no   = 0;
  int         quiet      = 0;
  int         hold_req   = 0;
  bit         gaps_on    = 1'b1;
  logic       seq_guess  = 1'b0;
  logic [7:0] payload_q[$];

  always #5 clk = ~clk;

  stop_and_wait_frame_receiver dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_rx_byte     (in_rx_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_kind       (out_kind),
    .out_data_byte  (out_data_byte),
    .out_byte_index (out_byte_index),
    .out_resp_first (out_resp_first),
    .out_resp_second(out_resp_second),
    .out_payload_len(out_payload_len),
    .out_last       (out_last)
  );

  sawfr_frame_checker checker_i (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_rx_byte     (in_rx_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_kind       (out_kind),
    .out_data_byte  (out_data_byte),
    .out_byte_index (out_byte_index),
    .out_resp_first (out_resp_first),
    .out_resp_second(out_resp_second),
    .out_payload_len(out_payload_len),
    .out_last       (out_last),
    .mismatches     (mismatches),
    .results_due    (results_due)
  );

  // result side: random stalls, plus a long hold-off on each hold request
  initial begin : result_sink
    int hold_left;
    int hold_seen;
    hold_left = 0;
    hold_seen = 0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = HOLD_CYCLES;
        out_stall <= 1'b1;
      end else begin
        out_stall <= gaps_on && ($urandom_range(99) < 8);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet <= 0;
      else quiet <= quiet + 1;
      if (quiet >= QUIET_LIMIT) begin
        $display("stop_and_wait_frame_receiver verification failed");
        $finish;
      end
    end
  end

  function automatic logic [7:0] payload_ones_sum();
    logic [8:0] acc;
    acc = '0;
    foreach (payload_q[i]) begin
      acc = {1'b0, acc[7:0]} + payload_q[i];
      if (acc[8]) acc = acc + 9'd1;
    end
    return acc[7:0];
  endfunction

  task automatic send_byte(input logic [7:0] b);
    if (gaps_on && $urandom_range(99) < 8) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_frame(input logic [7:0] csum, input logic [7:0] seq,
                            input logic [7:0] len);
    bit good;
    good = (csum == ~payload_ones_sum()) && (seq == {7'b0, seq_guess}) && (len <= MAX_LEN);
    send_byte(csum);
    send_byte(seq);
    send_byte(len);
    foreach (payload_q[i]) send_byte(payload_q[i]);
    if (good) seq_guess = ~seq_guess;
  endtask

  // drop valid and hold until every outstanding result has drained
  task automatic wait_for_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_due != 0) @(posedge clk);
  endtask

  task automatic random_frame();
    int         pick;
    int         len;
    logic [7:0] csum;
    logic [7:0] seq;
    logic [7:0] len_b;
    pick = (frame_no == 0) ? 0 : $urandom_range(99);
    if (frame_no == 0) len = MAX_LEN;
    else if ($urandom_range(24) == 0) len = $urandom_range(MAX_LEN);
    else len = $urandom_range(10);
    payload_q.delete();
    repeat (len) payload_q.push_back(8'($urandom_range(255)));
    csum  = ~payload_ones_sum();
    seq   = {7'b0, seq_guess};
    len_b = 8'(len);
    if (pick < 62) begin
      // well-formed: good checksum, expected sequence bit
    end else if (pick < 72) begin
      csum = csum ^ 8'($urandom_range(255, 1));
    end else if (pick < 80) begin
      seq = $urandom_range(1) ? {7'b0, ~seq_guess} : 8'($urandom_range(255));
    end else if (pick < 88) begin
      len_b = 8'($urandom_range(255, MAX_LEN + 1));
      payload_q.delete();
    end else begin
      // noise: every header byte random
      csum  = 8'($urandom_range(255));
      seq   = 8'($urandom_range(255));
      len_b = 8'($urandom_range(255));
      payload_q.delete();
      if (len_b <= MAX_LEN) begin
        len_b = {5'b0, len_b[2:0]};
        repeat (len_b) payload_q.push_back(8'($urandom_range(255)));
      end
    end
    send_frame(csum, seq, len_b);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty frame accepted, verdict on the length byte
    payload_q.delete();
    send_frame(8'hFF, 8'h00, 8'd0);
    // length just above the bound, then the largest length
    send_frame(8'h00, 8'h00, 8'd126);
    send_frame(8'hFF, 8'hFF, 8'hFF);
    // carry wraps around the payload sum
    payload_q = '{8'hFF, 8'hFF};
    send_frame(8'h00, 8'h01, 8'd2);
    // checksum error
    payload_q = '{8'h00};
    send_frame(8'h00, 8'h00, 8'd1);
    // sequence byte neither 0 nor 1
    payload_q = '{8'h5A};
    send_frame(8'hA5, 8'h80, 8'd1);
    // stale sequence bit on an empty frame
    payload_q.delete();
    send_frame(8'hFF, 8'h01, 8'd0);
    wait_for_results();

    while (bytes_sent < BYTE_TARGET) begin
      gaps_on = !(frame_no >= 50 && frame_no < 80);
      if (frame_no == 20 || frame_no == 110) hold_req++;
      if (frame_no == 40 || frame_no == 120) wait_for_results();
      random_frame();
      frame_no++;
    end

    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && results_due == 0) begin
      $display("stop_and_wait_frame_receiver verification clean");
    end else begin
      $display("stop_and_wait_frame_receiver verification failed");
    end
    $finish;
  end

endmodule
